@@ hw/rtl/best_fit_extent_allocator_top_assert.svh @@
// assertion macros for the extent allocator
`ifndef BEST_FIT_EXTENT_ALLOCATOR_TOP_ASSERT_SVH
`define BEST_FIT_EXTENT_ALLOCATOR_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define BFEA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define BFEA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hw/rtl/bfea_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package bfea_pkg;

    localparam int PAGE_BITS        = 32;
    localparam int FREE_ENTRIES_DEF = 64;
    localparam logic [31:0] CAP_RESET  = 32'd262144;
    localparam logic [4:0]  STEP_RESET = 5'd8;

    typedef logic [PAGE_BITS-1:0] t_page;

    // configuration register indexes
    typedef enum logic {
        CFG_CAPACITY = 1'b0,
        CFG_STEP     = 1'b1
    } t_cfg_idx;

    // request kinds
    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } t_req;

    typedef enum logic [2:0] {
        ST_OK   = 3'd0,
        ST_CAP  = 3'd1,
        ST_FULL = 3'd2,
        ST_ZERO = 3'd3,
        ST_DUP  = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WAIT,
        S_DECIDE,
        S_GROW1,
        S_GROW2,
        S_GROW3
    } t_state;

    // candidate flags gathered by the table scan
    typedef struct packed {
        logic best_f;
        logic large_f;
        logic last_f;
        logic prev_f;
        logic next_f;
        logic empty_f;
        logic dup;
    } t_scan_flags;

    // one free extent
    typedef struct packed {
        t_page start;
        t_page len;
    } t_ext;

endpackage
`default_nettype wire

@@ hw/rtl/bfea_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bfea_mem #(
    parameter int DEPTH = 64,
    parameter int IW    = 6
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [IW-1:0] i_waddr,
    input  wire bfea_pkg::t_ext i_wdata,
    input  wire logic [IW-1:0] i_raddr,
    output bfea_pkg::t_ext     o_rdata
);
    import bfea_pkg::*;

    t_ext r_mem [DEPTH];
    t_ext r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

@@ hw/rtl/bfea_scan.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bfea_scan #(
    parameter int IW = 6
) (
    input  wire logic            i_clk,
    input  wire logic            i_clear,
    input  wire logic            i_en,
    input  wire logic            i_vld,
    input  wire logic [IW-1:0]   i_idx,
    input  wire bfea_pkg::t_ext  i_ext,
    input  wire bfea_pkg::t_page i_req,
    input  wire bfea_pkg::t_page i_off,
    output bfea_pkg::t_scan_flags o_flags,
    output logic [IW-1:0]        o_best_idx,
    output logic [IW-1:0]        o_large_idx,
    output logic [IW-1:0]        o_last_idx,
    output logic [IW-1:0]        o_prev_idx,
    output logic [IW-1:0]        o_next_idx,
    output logic [IW-1:0]        o_empty_idx,
    output bfea_pkg::t_ext       o_best,
    output bfea_pkg::t_ext       o_large,
    output bfea_pkg::t_ext       o_last,
    output bfea_pkg::t_ext       o_prev,
    output bfea_pkg::t_ext       o_next
);
    import bfea_pkg::*;

    t_scan_flags r_f;
    logic [IW-1:0] r_bi, r_li, r_ti, r_pi, r_ni, r_ei;
    t_ext r_b, r_l, r_t, r_p, r_n;

    logic take_best, take_large, take_last, take_prev, take_next, is_dup;

    // compare bank applied to one entry per cycle
    always_comb begin
        take_best  = (i_ext.len >= i_req) &&
                     (!r_f.best_f || i_ext.len < r_b.len ||
                      (i_ext.len == r_b.len && i_ext.start < r_b.start));
        take_large = !r_f.large_f || i_ext.len > r_l.len ||
                     (i_ext.len == r_l.len && i_ext.start > r_l.start);
        take_last  = !r_f.last_f || i_ext.start > r_t.start;
        is_dup     = i_ext.start == i_off;
        take_prev  = (i_ext.start < i_off) && (!r_f.prev_f || i_ext.start > r_p.start);
        take_next  = (i_ext.start > i_off) && (!r_f.next_f || i_ext.start < r_n.start);
    end

    // running candidates
    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            r_f <= '0;
        end else if (i_en) begin
            if (i_vld) begin
                if (take_best) begin
                    r_f.best_f <= 1'b1;
                    r_bi       <= i_idx;
                    r_b        <= i_ext;
                end
                if (take_large) begin
                    r_f.large_f <= 1'b1;
                    r_li        <= i_idx;
                    r_l         <= i_ext;
                end
                if (take_last) begin
                    r_f.last_f <= 1'b1;
                    r_ti       <= i_idx;
                    r_t        <= i_ext;
                end
                if (is_dup) begin
                    r_f.dup <= 1'b1;
                end
                if (take_prev) begin
                    r_f.prev_f <= 1'b1;
                    r_pi       <= i_idx;
                    r_p        <= i_ext;
                end
                if (take_next) begin
                    r_f.next_f <= 1'b1;
                    r_ni       <= i_idx;
                    r_n        <= i_ext;
                end
            end else if (!r_f.empty_f) begin
                r_f.empty_f <= 1'b1;
                r_ei        <= i_idx;
            end
        end
    end

    assign o_flags     = r_f;
    assign o_best_idx  = r_bi;
    assign o_large_idx = r_li;
    assign o_last_idx  = r_ti;
    assign o_prev_idx  = r_pi;
    assign o_next_idx  = r_ni;
    assign o_empty_idx = r_ei;
    assign o_best      = r_b;
    assign o_large     = r_l;
    assign o_last      = r_t;
    assign o_prev      = r_p;
    assign o_next      = r_n;
endmodule
`default_nettype wire

@@ hw/rtl/best_fit_extent_allocator_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "best_fit_extent_allocator_top_assert.svh"
// Best-fit page extent allocator with coalescing free list.
// Requests: raise start with req_type, extent_offset, extent_pages; an item is
// taken when start is high and busy is low. busy stays high while it works.
// Each item gives one result on the o_ ports for one cycle, marked by o_done;
// the receiver always takes it and cannot stall the block.
// Configuration: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data;
// o_cfg_ready is high only while the block is idle, so a write never lands mid item.
// Timing: every nonzero request scans all FREE_ENTRIES table entries, one per
// cycle through the single read port of the extent memory, then decides.
// A fit or free then ends in S_DECIDE after S_WAIT; a reserve growth goes on
// through S_GROW1, S_GROW2 and S_GROW3, a capacity fault ends in S_GROW2,
// and a zero-size request is answered straight from S_IDLE.
// One item is in flight at a time: no new item is taken until the last is done.
// Reset empties the table (valid bits cleared), zeroes reserve and counters
// and loads default capacity and step; no clearing pass is needed.
module best_fit_extent_allocator_top #(
    parameter int FREE_ENTRIES = bfea_pkg::FREE_ENTRIES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_req_type,
    input  wire logic [31:0] i_extent_offset,
    input  wire logic [31:0] i_extent_pages,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    output logic             o_done,
    output logic [2:0]       o_status,
    output logic [31:0]      o_granted_offset,
    output logic [31:0]      o_granted_pages,
    output logic [31:0]      o_pages_in_use,
    output logic [31:0]      o_pages_committed
);
    import bfea_pkg::*;

    localparam int IW = (FREE_ENTRIES > 1) ? $clog2(FREE_ENTRIES) : 1;

    t_state r_state, n_state;
    logic [IW-1:0] r_addr, n_addr;
    logic r_pv, r_pvld;
    logic [IW-1:0] r_pidx;
    logic r_type, n_type;
    t_page r_off, n_off, r_len, n_len;
    t_page r_cap, r_rtop, n_rtop, r_used, n_used, r_comm, n_comm;
    logic [4:0] r_k;
    logic [FREE_ENTRIES-1:0] r_valid, n_valid;
    t_page r_tc, n_tc, r_goff_g, n_goff_g;
    logic r_merge, n_merge;
    logic [PAGE_BITS:0] r_total, n_total;
    logic r_done, n_done;
    t_status r_status, n_status;
    t_page r_gof, n_gof, r_gpg, n_gpg;

    logic we;
    logic [IW-1:0] waddr;
    t_ext wdata, rdata;
    logic scan_clear;
    logic err_done, take_nz;

    t_scan_flags sf;
    logic [IW-1:0] bi, li, ti, pi, ni, ei;
    t_ext eb, el, et, ep, en;

    // extent table storage
    bfea_mem #(.DEPTH(FREE_ENTRIES), .IW(IW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_addr),
        .o_rdata (rdata)
    );

    // shared compare unit walking the table
    bfea_scan #(.IW(IW)) u_scan (
        .i_clk       (i_clk),
        .i_clear     (scan_clear),
        .i_en        (r_pv),
        .i_vld       (r_pvld),
        .i_idx       (r_pidx),
        .i_ext       (rdata),
        .i_req       (r_len),
        .i_off       (r_off),
        .o_flags     (sf),
        .o_best_idx  (bi),
        .o_large_idx (li),
        .o_last_idx  (ti),
        .o_prev_idx  (pi),
        .o_next_idx  (ni),
        .o_empty_idx (ei),
        .o_best      (eb),
        .o_large     (el),
        .o_last      (et),
        .o_prev      (ep),
        .o_next      (en)
    );

    // neighbor and growth arithmetic
    logic prev_merge, next_merge, last_merge, step_big, over_cap, total_big;
    logic [PAGE_BITS:0] step_pow, step_mask, round_up, total_calc;
    t_page tc_calc;

    assign prev_merge = sf.prev_f &&
        (({1'b0, ep.start} + {1'b0, ep.len}) == {1'b0, r_off});
    assign next_merge = sf.next_f &&
        (({1'b0, r_off} + {1'b0, r_len}) == {1'b0, en.start});
    assign last_merge = sf.last_f &&
        (({1'b0, et.start} + {1'b0, et.len}) == {1'b0, r_rtop});
    assign step_pow   = (PAGE_BITS+1)'(1) << r_k;
    assign step_mask  = step_pow - (PAGE_BITS+1)'(1);
    assign step_big   = step_pow > {1'b0, r_cap};
    assign round_up   = ({1'b0, r_len} + step_mask) & ~step_mask;
    assign tc_calc    = (step_big || round_up > {1'b0, r_cap}) ? r_cap
                                                                : round_up[PAGE_BITS-1:0];
    assign over_cap   = (r_tc == '0) || (({1'b0, r_rtop} + {1'b0, r_tc}) > {1'b0, r_cap});
    assign total_calc = {1'b0, r_tc} + (r_merge ? {1'b0, et.len} : '0);
    assign total_big  = r_total > {1'b0, r_len};

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_addr   = r_addr;
        n_type   = r_type;
        n_off    = r_off;
        n_len    = r_len;
        n_rtop   = r_rtop;
        n_used   = r_used;
        n_comm   = r_comm;
        n_valid  = r_valid;
        n_tc     = r_tc;
        n_merge  = r_merge;
        n_total  = r_total;
        n_goff_g = r_goff_g;
        n_done   = 1'b0;
        n_status = r_status;
        n_gof    = r_gof;
        n_gpg    = r_gpg;
        we         = 1'b0;
        waddr      = '0;
        wdata      = '0;
        scan_clear = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_type = i_req_type;
                    n_off  = i_extent_offset;
                    n_len  = i_extent_pages;
                    if (i_extent_pages == '0) begin
                        n_done   = 1'b1;
                        n_status = ST_ZERO;
                        n_gof    = '0;
                        n_gpg    = '0;
                    end else begin
                        n_state    = S_SCAN;
                        n_addr     = '0;
                        scan_clear = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                n_addr = r_addr + IW'(1);
                if (r_addr == IW'(FREE_ENTRIES - 1)) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_state  = S_IDLE;
                n_done   = 1'b1;
                n_status = ST_OK;
                n_gof    = '0;
                n_gpg    = '0;
                if (r_type == REQ_FREE) begin
                    // insert and coalesce
                    if (sf.dup) begin
                        n_status = ST_DUP;
                    end else if (prev_merge) begin
                        we    = 1'b1;
                        waddr = pi;
                        wdata.start = ep.start;
                        wdata.len   = ep.len + r_len + (next_merge ? en.len : '0);
                        if (next_merge) begin
                            n_valid[ni] = 1'b0;
                        end
                        n_used = r_used - r_len;
                    end else if (next_merge) begin
                        we    = 1'b1;
                        waddr = ni;
                        wdata.start = r_off;
                        wdata.len   = en.len + r_len;
                        n_used = r_used - r_len;
                    end else if (sf.empty_f) begin
                        we    = 1'b1;
                        waddr = ei;
                        wdata.start = r_off;
                        wdata.len   = r_len;
                        n_valid[ei] = 1'b1;
                        n_used = r_used - r_len;
                    end else begin
                        n_status = ST_FULL;
                    end
                end else if (sf.best_f) begin
                    // best fit, split or taken whole
                    n_gof = eb.start;
                    n_gpg = r_len;
                    if (eb.len == r_len) begin
                        n_valid[bi] = 1'b0;
                    end else begin
                        we    = 1'b1;
                        waddr = bi;
                        wdata.start = eb.start + r_len;
                        wdata.len   = eb.len - r_len;
                    end
                    n_used = r_used + r_len;
                end else if (sf.large_f && el.len >= (r_len >> 2)) begin
                    // quarter fallback on the largest extent
                    n_gof = el.start;
                    n_gpg = el.len;
                    n_valid[li] = 1'b0;
                    n_used = r_used + el.len;
                end else begin
                    n_done  = 1'b0;
                    n_state = S_GROW1;
                end
            end
            S_GROW1: begin
                n_tc    = tc_calc;
                n_merge = last_merge;
                n_state = S_GROW2;
            end
            S_GROW2: begin
                if (over_cap) begin
                    n_state  = S_IDLE;
                    n_done   = 1'b1;
                    n_status = ST_CAP;
                end else begin
                    n_total  = total_calc;
                    n_goff_g = r_merge ? et.start : r_rtop;
                    n_state  = S_GROW3;
                end
            end
            S_GROW3: begin
                n_state  = S_IDLE;
                n_done   = 1'b1;
                n_status = ST_OK;
                if (total_big && !r_merge && !sf.empty_f) begin
                    n_status = ST_FULL;
                end else begin
                    n_gof = r_goff_g;
                    if (total_big) begin
                        we    = 1'b1;
                        waddr = r_merge ? ti : ei;
                        wdata.start = r_goff_g + r_len;
                        wdata.len   = r_total[PAGE_BITS-1:0] - r_len;
                        n_valid[waddr] = 1'b1;
                        n_gpg  = r_len;
                        n_used = r_used + r_len;
                    end else begin
                        if (r_merge) begin
                            n_valid[ti] = 1'b0;
                        end
                        n_gpg  = r_total[PAGE_BITS-1:0];
                        n_used = r_used + r_total[PAGE_BITS-1:0];
                    end
                    n_rtop = r_rtop + r_tc;
                    n_comm = r_comm + r_tc;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (n_status != ST_OK) begin
            n_gof = '0;
            n_gpg = '0;
        end
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_done   <= 1'b0;
            r_pv     <= 1'b0;
            r_valid  <= '0;
            r_rtop   <= '0;
            r_used   <= '0;
            r_comm   <= '0;
            r_cap    <= CAP_RESET;
            r_k      <= STEP_RESET;
            r_status <= ST_OK;
            r_gof    <= '0;
            r_gpg    <= '0;
        end else begin
            r_state  <= n_state;
            r_done   <= n_done;
            r_pv     <= (r_state == S_SCAN);
            r_valid  <= n_valid;
            r_rtop   <= n_rtop;
            r_used   <= n_used;
            r_comm   <= n_comm;
            r_status <= n_status;
            r_gof    <= n_gof;
            r_gpg    <= n_gpg;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_CAPACITY) begin
                    r_cap <= i_cfg_data;
                end else begin
                    r_k <= i_cfg_data[4:0];
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_pidx   <= r_addr;
        r_pvld   <= r_valid[r_addr];
        r_type   <= n_type;
        r_off    <= n_off;
        r_len    <= n_len;
        r_tc     <= n_tc;
        r_merge  <= n_merge;
        r_total  <= n_total;
        r_goff_g <= n_goff_g;
    end

    assign busy              = (r_state != S_IDLE);
    assign o_cfg_ready       = (r_state == S_IDLE);
    assign o_done            = r_done;
    assign o_status          = r_status;
    assign o_granted_offset  = r_gof;
    assign o_granted_pages   = r_gpg;
    assign o_pages_in_use    = r_used;
    assign o_pages_committed = r_comm;

    // assertion helpers
    assign err_done = o_done && (o_status != ST_OK);
    assign take_nz  = start && !busy && (i_extent_pages != 32'd0);

    `BFEA_ASSERT_NOW(a_done_idle, i_clk, i_rst_n, o_done, !busy)
    `BFEA_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, take_nz, busy && !o_done)
    `BFEA_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, err_done, (o_granted_pages | o_granted_offset) == '0)
    `BFEA_ASSERT_NOW(a_scan_only_busy, i_clk, i_rst_n, r_pv, busy)
endmodule
`default_nettype wire

@@ dv/tb_best_fit_extent_allocator_top.sv @@
`timescale 1ns / 1ps
module tb_best_fit_extent_allocator_top;
    import bfea_pkg::*;

    localparam int NUM_EXT = 64;

    typedef struct packed {
        t_status     status;
        logic [31:0] goff;
        logic [31:0] gpages;
        logic [31:0] used;
        logic [31:0] committed;
    } t_grant;

    typedef struct {
        t_req        kind;
        logic [31:0] off;
        logic [31:0] pages;
        bit          typed;
        t_grant      want;
    } t_row;

    typedef struct {
        logic [31:0] off;
        logic [31:0] pages;
    } t_span;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_req_type;
    logic [31:0] i_extent_offset;
    logic [31:0] i_extent_pages;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        o_done;
    logic [2:0]  o_status;
    logic [31:0] o_granted_offset;
    logic [31:0] o_granted_pages;
    logic [31:0] o_pages_in_use;
    logic [31:0] o_pages_committed;

    // shadow of the allocator state
    logic [63:0] ext_start [NUM_EXT];
    logic [63:0] ext_len [NUM_EXT];
    bit          ext_vld [NUM_EXT];
    logic [63:0] rsv_top;
    logic [63:0] used_pages;
    logic [63:0] comm_pages;
    logic [63:0] cap_pages;
    logic [63:0] step_log2;

    t_grant grant_q[$];
    t_span  owned[$];
    int     errors;
    bit     no_gaps;

    best_fit_extent_allocator_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_req_type       (i_req_type),
        .i_extent_offset  (i_extent_offset),
        .i_extent_pages   (i_extent_pages),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_granted_offset (o_granted_offset),
        .o_granted_pages  (o_granted_pages),
        .o_pages_in_use   (o_pages_in_use),
        .o_pages_committed(o_pages_committed)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #20ms;
        $display("best_fit_extent_allocator_top verification failed");
        $finish;
    end

    function automatic int first_empty();
        for (int i = 0; i < NUM_EXT; i++)
            if (!ext_vld[i])
                return i;
        return -1;
    endfunction

    // best fit, quarter fallback, then reserve growth
    task automatic alloc_pages(input logic [63:0] req, output t_status st,
                               output logic [63:0] goff, output logic [63:0] gp);
        int          best;
        int          largest;
        int          last;
        int          slot;
        logic [63:0] step;
        logic [63:0] tc;
        logic [63:0] off;
        logic [63:0] total;
        best = -1;
        largest = -1;
        last = -1;
        st = ST_OK;
        goff = 0;
        gp = 0;
        for (int i = 0; i < NUM_EXT; i++) begin
            if (!ext_vld[i])
                continue;
            if (ext_len[i] >= req && (best < 0 || ext_len[i] < ext_len[best] ||
                (ext_len[i] == ext_len[best] && ext_start[i] < ext_start[best])))
                best = i;
            if (largest < 0 || ext_len[i] > ext_len[largest] ||
                (ext_len[i] == ext_len[largest] && ext_start[i] > ext_start[largest]))
                largest = i;
            if (last < 0 || ext_start[i] > ext_start[last])
                last = i;
        end
        if (best >= 0) begin
            goff = ext_start[best];
            gp = req;
            if (ext_len[best] == req) begin
                ext_vld[best] = 0;
            end else begin
                ext_start[best] = (ext_start[best] + req) & 64'hFFFF_FFFF;
                ext_len[best] = ext_len[best] - req;
            end
            used_pages = (used_pages + req) & 64'hFFFF_FFFF;
            return;
        end
        if (largest >= 0 && ext_len[largest] >= req / 4) begin
            goff = ext_start[largest];
            gp = ext_len[largest];
            ext_vld[largest] = 0;
            used_pages = (used_pages + gp) & 64'hFFFF_FFFF;
            return;
        end
        step = 64'd1 << step_log2[4:0];
        if (step > cap_pages)
            step = cap_pages;
        if (step == 0)
            step = 1;
        tc = (req + step - 1) / step * step;
        if (tc > cap_pages)
            tc = cap_pages;
        if (tc == 0 || rsv_top + tc > cap_pages) begin
            st = ST_CAP;
            return;
        end
        off = rsv_top;
        total = tc;
        slot = -1;
        if (last >= 0 && ext_start[last] + ext_len[last] == rsv_top) begin
            off = ext_start[last];
            total += ext_len[last];
            slot = last;
        end
        if (total > req && slot < 0) begin
            slot = first_empty();
            if (slot < 0) begin
                st = ST_FULL;
                return;
            end
        end
        if (total > req) begin
            ext_start[slot] = (off + req) & 64'hFFFF_FFFF;
            ext_len[slot] = (total - req) & 64'hFFFF_FFFF;
            ext_vld[slot] = 1;
            gp = req;
        end else begin
            if (slot >= 0)
                ext_vld[slot] = 0;
            gp = total & 64'hFFFF_FFFF;
        end
        goff = off & 64'hFFFF_FFFF;
        rsv_top = (rsv_top + tc) & 64'hFFFF_FFFF;
        comm_pages = (comm_pages + tc) & 64'hFFFF_FFFF;
        used_pages = (used_pages + gp) & 64'hFFFF_FFFF;
    endtask

    // insert an extent, coalescing with both neighbors
    task automatic release_pages(input logic [63:0] off, input logic [63:0] len,
                                 output t_status st);
        int prev;
        int nxt;
        int slot;
        bit mprev;
        bit mnext;
        prev = -1;
        nxt = -1;
        st = ST_OK;
        for (int i = 0; i < NUM_EXT; i++) begin
            if (!ext_vld[i])
                continue;
            if (ext_start[i] == off) begin
                st = ST_DUP;
                return;
            end
            if (ext_start[i] < off) begin
                if (prev < 0 || ext_start[i] > ext_start[prev])
                    prev = i;
            end else begin
                if (nxt < 0 || ext_start[i] < ext_start[nxt])
                    nxt = i;
            end
        end
        mprev = prev >= 0 && ext_start[prev] + ext_len[prev] == off;
        mnext = nxt >= 0 && off + len == ext_start[nxt];
        if (mprev) begin
            ext_len[prev] += len;
            if (mnext) begin
                ext_len[prev] += ext_len[nxt];
                ext_vld[nxt] = 0;
            end
            ext_len[prev] &= 64'hFFFF_FFFF;
        end else if (mnext) begin
            ext_start[nxt] = off;
            ext_len[nxt] = (ext_len[nxt] + len) & 64'hFFFF_FFFF;
        end else begin
            slot = first_empty();
            if (slot < 0) begin
                st = ST_FULL;
                return;
            end
            ext_start[slot] = off;
            ext_len[slot] = len;
            ext_vld[slot] = 1;
        end
        used_pages = (used_pages - len) & 64'hFFFF_FFFF;
    endtask

    task automatic predict_grant(input t_req kind, input logic [31:0] off,
                                 input logic [31:0] pages, output t_grant g);
        t_status     st;
        logic [63:0] goff;
        logic [63:0] gp;
        goff = 0;
        gp = 0;
        if (pages == 0)
            st = ST_ZERO;
        else if (kind == REQ_ALLOC)
            alloc_pages({32'd0, pages}, st, goff, gp);
        else
            release_pages({32'd0, off}, {32'd0, pages}, st);
        if (st != ST_OK) begin
            goff = 0;
            gp = 0;
        end
        g.status = st;
        g.goff = goff[31:0];
        g.gpages = gp[31:0];
        g.used = used_pages[31:0];
        g.committed = comm_pages[31:0];
        if (kind == REQ_ALLOC && st == ST_OK)
            owned.insert(owned.size(), t_span'{goff[31:0], gp[31:0]});
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", field, got, want, $realtime);
        errors++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_grant w;
        if (i_rst_n && o_done) begin
            if (grant_q.size() == 0) begin
                report_mismatch("unexpected item", 32'd0, 32'd0);
            end else begin
                w = grant_q.pop_front();
                if (o_status != w.status)
                    report_mismatch("status", {29'd0, o_status}, {29'd0, w.status});
                if (o_granted_offset != w.goff)
                    report_mismatch("granted_offset", o_granted_offset, w.goff);
                if (o_granted_pages != w.gpages)
                    report_mismatch("granted_pages", o_granted_pages, w.gpages);
                if (o_pages_in_use != w.used)
                    report_mismatch("pages_in_use", o_pages_in_use, w.used);
                if (o_pages_committed != w.committed)
                    report_mismatch("pages_committed", o_pages_committed, w.committed);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // issue one item, typed expectation used when given
    task automatic send_item(input t_req kind, input logic [31:0] off,
                             input logic [31:0] pages, input bit typed,
                             input t_grant want);
        t_grant g;
        int     gap;
        gap = pick_gap();
        @(negedge i_clk);
        repeat (gap) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        while (busy) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_req_type <= kind;
        i_extent_offset <= off;
        i_extent_pages <= pages;
        predict_grant(kind, off, pages, g);
        grant_q.insert(grant_q.size(), typed ? want : g);
        @(posedge i_clk);
    endtask

    task automatic send_pred(input t_req kind, input logic [31:0] off,
                             input logic [31:0] pages);
        send_item(kind, off, pages, 1'b0, '0);
    endtask

    // wait for every result, then for the block to settle
    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (grant_q.size() != 0 || busy)
            @(negedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [31:0] data);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_CAPACITY)
            cap_pages = {32'd0, data};
        else
            step_log2 = {59'd0, data[4:0]};
    endtask

    function automatic logic [31:0] rand_pages();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 600);
        if (r < 85)
            return $urandom_range(1, 8);
        if (r < 92)
            return $urandom_range(600, 5000);
        if (r < 96)
            return 32'd0;
        return $urandom();
    endfunction

    // mostly alloc / free of owned spans, with noise
    task automatic random_burst(input int count);
        int          r;
        int          k;
        t_span       sp;
        logic [31:0] part;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 99) == 0)
                drain();
            if (r < 45 || owned.size() == 0) begin
                send_pred(REQ_ALLOC, $urandom(), rand_pages());
            end else if (r < 85) begin
                k = $urandom_range(0, owned.size() - 1);
                sp = owned[k];
                owned.delete(k);
                if (sp.pages > 1 && $urandom_range(0, 3) == 0) begin
                    // give back the head, keep the tail
                    part = $urandom_range(1, sp.pages - 1);
                    owned.insert(owned.size(), t_span'{sp.off + part, sp.pages - part});
                    sp.pages = part;
                end
                send_pred(REQ_FREE, sp.off, sp.pages);
            end else if (r < 90 && owned.size() != 0) begin
                send_pred(REQ_FREE, owned[0].off, 32'd1);
            end else begin
                send_pred(t_req'($urandom_range(0, 1)), $urandom(), rand_pages());
            end
        end
    endtask

    t_row rows[$];

    initial begin
        errors = 0;
        no_gaps = 0;
        start = 1'b0;
        i_req_type = 1'b0;
        i_extent_offset = '0;
        i_extent_pages = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = 1'b0;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        for (int i = 0; i < NUM_EXT; i++) begin
            ext_start[i] = 0;
            ext_len[i] = 0;
            ext_vld[i] = 0;
        end
        rsv_top = 0;
        used_pages = 0;
        comm_pages = 0;
        cap_pages = {32'd0, CAP_RESET};
        step_log2 = {59'd0, STEP_RESET};
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows
        rows.insert(rows.size(), t_row'{REQ_ALLOC, 32'd0, 32'd0, 1, '{ST_ZERO, 0, 0, 0, 0}});
        rows.insert(rows.size(), t_row'{REQ_FREE, 32'd5, 32'd0, 1, '{ST_ZERO, 0, 0, 0, 0}});
        rows.insert(rows.size(), t_row'{REQ_ALLOC, 32'd9, 32'd1, 1, '{ST_OK, 0, 1, 1, 256}});
        rows.insert(rows.size(),
                    t_row'{REQ_ALLOC, 32'd0, 32'd255, 1, '{ST_OK, 1, 255, 256, 256}});
        rows.insert(rows.size(),
                    t_row'{REQ_ALLOC, 32'd0, 32'hFFFF_FFFF, 1, '{ST_CAP, 0, 0, 256, 256}});
        rows.insert(rows.size(), t_row'{REQ_FREE, 32'd0, 32'd1, 1, '{ST_OK, 0, 0, 255, 256}});
        rows.insert(rows.size(), t_row'{REQ_FREE, 32'd0, 32'd4, 1, '{ST_DUP, 0, 0, 255, 256}});
        rows.insert(rows.size(), t_row'{REQ_FREE, 32'd1, 32'd10, 0, '0});
        rows.insert(rows.size(), t_row'{REQ_FREE, 32'd20, 32'd5, 0, '0});
        rows.insert(rows.size(), t_row'{REQ_FREE, 32'd11, 32'd9, 0, '0});
        rows.insert(rows.size(), t_row'{REQ_FREE, 32'd40, 32'd3, 0, '0});
        rows.insert(rows.size(), t_row'{REQ_FREE, 32'd60, 32'd30, 0, '0});
        rows.insert(rows.size(), t_row'{REQ_ALLOC, 32'd0, 32'd3, 0, '0});
        rows.insert(rows.size(), t_row'{REQ_ALLOC, 32'd0, 32'd100, 0, '0});
        rows.insert(rows.size(), t_row'{REQ_ALLOC, 32'd0, 32'd400, 0, '0});
        rows.insert(rows.size(), t_row'{REQ_FREE, 32'd300, 32'd100, 0, '0});
        rows.insert(rows.size(), t_row'{REQ_ALLOC, 32'd0, 32'd700, 0, '0});
        rows.insert(rows.size(), t_row'{REQ_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, '0});
        rows.insert(rows.size(), t_row'{REQ_FREE, 32'hFFFF_FFF0, 32'd15, 0, '0});
        rows.insert(rows.size(), t_row'{REQ_ALLOC, 32'hFFFF_FFFF, 32'h8000_0000, 0, '0});
        rows.insert(rows.size(), t_row'{REQ_ALLOC, 32'd0, 32'h4000_0000, 0, '0});
        rows.insert(rows.size(), t_row'{REQ_ALLOC, 32'd0, 32'd1, 0, '0});
        foreach (rows[i])
            send_item(rows[i].kind, rows[i].off, rows[i].pages, rows[i].typed,
                      rows[i].want);

        // table fill: scattered frees until the table is full
        no_gaps = 1;
        for (int i = 0; i < 70; i++)
            send_pred(REQ_FREE, 32'h0100_0000 + 3 * i, 32'd1);
        send_pred(REQ_ALLOC, 32'd0, 32'd50000);
        no_gaps = 0;
        random_burst(150);

        // tiny capacity, unit step
        cfg_write(CFG_CAPACITY, 32'd1);
        cfg_write(CFG_STEP, 5'd0);
        random_burst(60);

        // widest capacity, largest step
        cfg_write(CFG_CAPACITY, 32'hFFFF_FFFF);
        cfg_write(CFG_STEP, 5'd31);
        send_pred(REQ_ALLOC, 32'd0, 32'hFFFF_FFFF);
        random_burst(150);

        // mid settings, bursts with and without gaps
        cfg_write(CFG_STEP, 5'd4);
        no_gaps = 1;
        random_burst(150);
        no_gaps = 0;
        random_burst(150);

        for (int p = 0; p < 3; p++) begin
            cfg_write(CFG_CAPACITY, $urandom());
            cfg_write(CFG_STEP, $urandom_range(0, 31));
            random_burst(100);
        end

        drain();
        if (errors == 0)
            $display("best_fit_extent_allocator_top verification clean");
        else
            $display("best_fit_extent_allocator_top verification failed");
        $finish;
    end

endmodule

@@ best_fit_extent_allocator_top.f @@
+incdir+hw/rtl
hw/rtl/bfea_pkg.sv
hw/rtl/bfea_mem.sv
hw/rtl/bfea_scan.sv
hw/rtl/best_fit_extent_allocator_top.sv
dv/tb_best_fit_extent_allocator_top.sv
